// ===== rtl/ile_pkg.sv =====
// Shared opcodes, status codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int OP_W   = 4;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int EXT_W  = 64;

    localparam logic [OP_W-1:0] OP_APPEND    = 4'd0;
    localparam logic [OP_W-1:0] OP_PREPEND   = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT    = 4'd2;
    localparam logic [OP_W-1:0] OP_SET       = 4'd3;
    localparam logic [OP_W-1:0] OP_GET       = 4'd4;
    localparam logic [OP_W-1:0] OP_TAKE      = 4'd5;
    localparam logic [OP_W-1:0] OP_POP_FIRST = 4'd6;
    localparam logic [OP_W-1:0] OP_POP_LAST  = 4'd7;
    localparam logic [OP_W-1:0] OP_FIRST     = 4'd8;
    localparam logic [OP_W-1:0] OP_LAST      = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // read address select
    localparam logic [1:0] RA_PTR    = 2'd0;
    localparam logic [1:0] RA_PTR_M1 = 2'd1;
    localparam logic [1:0] RA_PTR_P1 = 2'd2;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_rdata;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       cap_rd;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            ptr_at_pos;
        logic            ptr_at_last;
    } t_dp_sts;

endpackage

// ===== rtl/ile_dp.sv =====
// List engine datapath: entry memory, count, pointer and result registers.
`timescale 1ns / 1ps

module ile_dp
    import ile_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [VAL_W-1:0]  i_value,
    output logic [VAL_W-1:0]  o_read_value,
    output logic [STAT_W-1:0] o_status,
    output logic [CNT_W-1:0]  o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_pos;
    logic [OP_W-1:0]       r_op;
    logic [STAT_W-1:0]     r_stat;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [VAL_W-1:0]      r_out_rd;
    logic [STAT_W-1:0]     r_out_status;
    logic [CNT_W-1:0]      r_out_count;

    logic [31:0]           w_idx_big;
    logic [31:0]           w_cnt_big;
    logic [CW-1:0]         w_idx_cw;
    logic [STAT_W-1:0]     w_status;
    logic [CW-1:0]         w_ptr0;
    logic [CW-1:0]         w_pos0;
    logic [CW-1:0]         w_rd_ptr;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [EXT_W-1:0]      w_val_ext;
    logic [EXT_W-1:0]      w_rd_ext;
    logic [31:0]           w_cnt_ext;
    logic [CW:0]           w_ptr_nx;

    assign w_idx_big = 32'(i_index);
    assign w_cnt_big = 32'(r_count);
    assign w_idx_cw  = w_idx_big[CW-1:0];
    assign w_val_ext = EXT_W'(i_value);
    assign w_rd_ext  = EXT_W'(r_rd);
    assign w_cnt_ext = 32'(r_count);

    always_comb begin
        w_status = ST_OK;
        unique case (i_opcode) inside
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
                if (w_cnt_big == CAPACITY) begin
                    w_status = ST_FULL;
                end else if (i_opcode == OP_INSERT && w_idx_big > w_cnt_big) begin
                    w_status = ST_RANGE;
                end
            end
            OP_SET, OP_GET, OP_TAKE: begin
                if (w_idx_big >= w_cnt_big) begin
                    w_status = ST_RANGE;
                end
            end
            OP_POP_FIRST, OP_POP_LAST, OP_FIRST, OP_LAST: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end
            end
            default: w_status = ST_RANGE;
        endcase
    end

    // insert ops: pointer at destination of first move, pos is the gap
    always_comb begin
        w_ptr0 = '0;
        w_pos0 = '0;
        unique case (i_opcode) inside
            OP_APPEND: begin
                w_ptr0 = r_count;
                w_pos0 = r_count;
            end
            OP_PREPEND: begin
                w_ptr0 = r_count;
                w_pos0 = '0;
            end
            OP_INSERT: begin
                w_ptr0 = r_count;
                w_pos0 = w_idx_cw;
            end
            OP_SET, OP_GET, OP_TAKE: begin
                w_ptr0 = w_idx_cw;
            end
            OP_POP_LAST, OP_LAST: begin
                w_ptr0 = r_count - 1'b1;
            end
            default: begin
                w_ptr0 = '0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            n_ptr = w_ptr0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + 1'b1;
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RA_PTR_M1: w_rd_ptr = r_ptr - 1'b1;
            RA_PTR_P1: w_rd_ptr = r_ptr + 1'b1;
            default:   w_rd_ptr = r_ptr;
        endcase
    end

    assign w_rd_addr = w_rd_ptr[AW-1:0];
    assign w_wr_data = i_cmd.wr_rdata ? r_rdata : r_val;
    assign w_ptr_nx  = {1'b0, r_ptr} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_pos  <= w_pos0;
            r_stat <= w_status;
            r_val  <= w_val_ext[DATA_WIDTH-1:0];
        end
        if (i_cmd.load) begin
            r_rd <= '0;
        end else if (i_cmd.cap_rd) begin
            r_rd <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_rd     <= w_rd_ext[VAL_W-1:0];
            r_out_status <= r_stat;
            r_out_count  <= w_cnt_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_ptr[AW-1:0]] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.err         = (r_stat != ST_OK);
    assign o_sts.ptr_at_pos  = (r_ptr == r_pos);
    assign o_sts.ptr_at_last = (w_ptr_nx == {1'b0, r_count});

    assign o_read_value  = r_out_rd;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

// ===== rtl/ile_ctrl.sv =====
// List engine controller: sequences memory reads, writes and shifts per operation.
`timescale 1ns / 1ps

module ile_ctrl
    import ile_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_WRITE    = 4'd2;
    localparam logic [3:0] S_OPEN     = 4'd3;
    localparam logic [3:0] S_OPEN_WR  = 4'd4;
    localparam logic [3:0] S_READ     = 4'd5;
    localparam logic [3:0] S_CAPT     = 4'd6;
    localparam logic [3:0] S_CLOSE    = 4'd7;
    localparam logic [3:0] S_CLOSE_WR = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_sts.op) inside
                        OP_APPEND, OP_SET:     n_state = S_WRITE;
                        OP_PREPEND, OP_INSERT: n_state = S_OPEN;
                        default:               n_state = S_READ;
                    endcase
                end
            end
            S_OPEN: begin
                if (i_sts.ptr_at_pos) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR_M1;
                    n_state      = S_OPEN_WR;
                end
            end
            S_OPEN_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_rdata = 1'b1;
                o_cmd.ptr_dec  = 1'b1;
                n_state        = S_OPEN;
            end
            S_WRITE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.cnt_inc = (i_sts.op != OP_SET);
                n_state       = S_DONE;
            end
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_PTR;
                n_state      = S_CAPT;
            end
            S_CAPT: begin
                o_cmd.cap_rd = 1'b1;
                if (i_sts.op == OP_POP_LAST) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.op == OP_TAKE || i_sts.op == OP_POP_FIRST) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLOSE: begin
                if (i_sts.ptr_at_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR_P1;
                    n_state      = S_CLOSE_WR;
                end
            end
            S_CLOSE_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_rdata = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                n_state        = S_CLOSE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/indexed_list_engine_core.sv =====
// Top level of the indexed list engine: controller plus datapath.
// One word at a time. An error goes straight to the result; append and set write one entry;
// get, first, last and pop last read one; insert and prepend shift the entries from pos up
// first, take and pop first shift the later ones down; each move is a read then a write.
// The next word is taken the cycle after the result register loads.
// Synchronous reset clears the count and handshake state; the entry memory is not cleared.
`timescale 1ns / 1ps

module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VAL_W-1:0]  o_read_value,
    output logic [STAT_W-1:0] o_status,
    output logic [CNT_W-1:0]  o_entry_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ile_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ile_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_index       (i_index),
        .i_value       (i_value),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

// ===== rtl/ile_checker.sv =====
// Port-level assertions for the indexed list engine, bound to the top level.
`timescale 1ns / 1ps

module ile_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [VAL_W-1:0]  o_read_value,
    input logic [STAT_W-1:0] o_status,
    input logic [CNT_W-1:0]  o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while one is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_read_value == '0)
        else $error("nonzero read value on failed operation");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind indexed_list_engine_core ile_checker #(
    .CAPACITY (CAPACITY)
) u_ile_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_read_value  (o_read_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
